// ===== rtl/prk_pkg.sv =====
`timescale 1ns / 1ps
package prk_pkg;

  localparam int DW = 32;
  localparam int FB = 24;
  localparam int NEVAL = 4;
  localparam int NHORNER = 5;

  // register indexes of the configuration port
  localparam logic [1:0] REG_STEP    = 2'd0;
  localparam logic [1:0] REG_DRIVE   = 2'd1;
  localparam logic [1:0] REG_GRAVITY = 2'd2;

  localparam logic [24:0] STEP_RST    = 25'd167772;
  localparam logic [30:0] DRIVE_RST   = 31'd166111;
  localparam logic [30:0] GRAVITY_RST = 31'd253241674;

  // h/6 by reciprocal, exact for every 25 bit h
  localparam int H6_SH = 27;
  localparam logic [63:0] H6_MUL = ((64'd1 << H6_SH) + 64'd5) / 64'd6;
  localparam logic [24:0] H6_RST = 25'((64'(STEP_RST) * H6_MUL) >> H6_SH);

  localparam logic [63:0] PI_Q60 = 64'd3622009729038561421;
  localparam logic [63:0] PI_FX = (PI_Q60 + (64'd1 << (59 - FB))) >> (60 - FB);
  localparam logic [63:0] HALF_FX = (PI_Q60 + (64'd1 << (60 - FB))) >> (61 - FB);
  localparam logic [63:0] TWO_PI_FX = 64'd2 * PI_FX;

  localparam logic signed [DW-1:0] PI_S = DW'(PI_FX);
  localparam logic signed [DW-1:0] HALF_S = DW'(HALF_FX);
  localparam logic signed [DW-1:0] TWO_PI_S = DW'(TWO_PI_FX);
  localparam logic signed [DW-1:0] ONE = DW'(64'd1 << FB);
  localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

  // range reduction: offset to a positive value, then quotient by reciprocal
  localparam int RED_UW = DW + 1;
  localparam int RED_SH = 40;
  localparam int RED_PW = RED_UW + 14;
  localparam int RED_QW = RED_PW - RED_SH;
  localparam int RED_RW = 28;
  localparam logic [63:0] RED_K = ((64'd1 << (DW - 1)) + TWO_PI_FX - 64'd1) / TWO_PI_FX;
  localparam logic [63:0] RED_OFS = RED_K * TWO_PI_FX;
  localparam logic [63:0] RED_RM = (64'd1 << RED_SH) / TWO_PI_FX;

  // series denominators and their reciprocals
  localparam logic [6:0] DIV_DEN [NHORNER] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  localparam int DIV_SH [NHORNER] = '{38, 38, 37, 36, 34};
  localparam logic [31:0] DIV_MUL [NHORNER] = '{
    32'((64'd1 << 38) / 64'd110), 32'((64'd1 << 38) / 64'd72),
    32'((64'd1 << 37) / 64'd42), 32'((64'd1 << 36) / 64'd20),
    32'((64'd1 << 34) / 64'd6)};

  typedef struct packed {
    logic              clip;
    logic signed [DW-1:0] v;
  } sres_t;

  typedef struct packed {
    logic signed [DW-1:0] th0;
    logic signed [DW-1:0] w0;
    logic signed [DW-1:0] drive;
    logic signed [DW-1:0] thc;
    logic signed [DW-1:0] okc;
    logic signed [DW-1:0] so;
    logic signed [DW-1:0] sw;
    logic                 clip;
  } st_t;

  function automatic sres_t smul(input logic signed [DW-1:0] a,
                                 input logic signed [DW-1:0] b);
    logic            neg;
    logic [DW-1:0]   ua;
    logic [DW-1:0]   ub;
    logic [2*DW-1:0] prod;
    logic [2*DW-1:0] q;
    logic [DW-1:0]   lim;
    logic [DW-1:0]   ql;
    sres_t           res;
    neg = a[DW-1] ^ b[DW-1];
    ua = a[DW-1] ? $unsigned(-a) : $unsigned(a);
    ub = b[DW-1] ? $unsigned(-b) : $unsigned(b);
    prod = {{DW{1'b0}}, ua} * {{DW{1'b0}}, ub};
    q = prod >> FB;
    lim = $unsigned(SMAX) + DW'(neg);
    res.clip = q > {{DW{1'b0}}, lim};
    ql = res.clip ? lim : q[DW-1:0];
    res.v = neg ? $signed(~ql + 1'b1) : $signed(ql);
    return res;
  endfunction

  function automatic sres_t sadd(input logic signed [DW-1:0] a,
                                 input logic signed [DW-1:0] b);
    logic signed [DW:0] s;
    sres_t              res;
    s = {a[DW-1], a} + {b[DW-1], b};
    res.clip = s[DW] != s[DW-1];
    if (res.clip) begin
      res.v = s[DW] ? SMIN : SMAX;
    end else begin
      res.v = s[DW-1:0];
    end
    return res;
  endfunction

  function automatic sres_t sneg(input logic signed [DW-1:0] a);
    sres_t res;
    res.clip = a == SMIN;
    res.v = res.clip ? SMAX : -a;
    return res;
  endfunction

endpackage

// ===== rtl/prk_sin.sv =====
`timescale 1ns / 1ps
module prk_sin (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  prk_pkg::st_t                 in_st,
  output logic                         out_valid,
  output prk_pkg::st_t                 out_st,
  output logic signed [prk_pkg::DW-1:0] out_sin
);
  import prk_pkg::*;

  // stage 1: offset and reciprocal product
  logic              v1_r;
  st_t               st1_r;
  logic [RED_UW-1:0] u1_r;
  logic [RED_PW-1:0] p1_r;
  logic [RED_UW-1:0] u1_nxt;

  // stage 2: remainder
  logic              v2_r;
  st_t               st2_r;
  logic [RED_RW-1:0] r2_r;
  logic [RED_QW-1:0] q2;

  // stage 3: final correction, move to [-pi, pi)
  logic                 v3_r;
  st_t                  st3_r;
  logic signed [DW-1:0] r3_r;
  logic signed [DW-1:0] r3_nxt;
  logic [RED_RW-1:0]    ra;

  // stage 4: fold into [-pi/2, pi/2]
  logic                 v4_r;
  st_t                  st4_r;
  logic signed [DW-1:0] r4_r;
  logic signed [DW-1:0] r4_nxt;

  // stage 5: square
  sres_t sq5;
  st_t   st5_nxt;

  logic                 hz_v  [NHORNER+1];
  st_t                  hz_st [NHORNER+1];
  logic signed [DW-1:0] hz_x2 [NHORNER+1];
  logic signed [DW-1:0] hz_r  [NHORNER+1];
  logic signed [DW-1:0] hz_t  [NHORNER+1];

  logic                 v5_r;
  st_t                  st5_r;
  logic signed [DW-1:0] x2_r;
  logic signed [DW-1:0] r5_r;

  sres_t sn;
  st_t   sto_nxt;
  logic  vo_r;
  st_t   sto_r;
  logic signed [DW-1:0] sin_r;

  assign u1_nxt = {in_st.thc[DW-1], in_st.thc} + RED_UW'(RED_OFS);
  assign q2 = p1_r[RED_PW-1:RED_SH];

  always_comb begin
    ra = (r2_r >= RED_RW'(TWO_PI_FX)) ? r2_r - RED_RW'(TWO_PI_FX) : r2_r;
    if (ra >= RED_RW'(PI_FX)) begin
      r3_nxt = $signed(DW'(ra)) - TWO_PI_S;
    end else begin
      r3_nxt = $signed(DW'(ra));
    end
  end

  always_comb begin
    if (r3_r > HALF_S) begin
      r4_nxt = PI_S - r3_r;
    end else if (r3_r < -HALF_S) begin
      r4_nxt = -PI_S - r3_r;
    end else begin
      r4_nxt = r3_r;
    end
  end

  assign sq5 = smul(r4_r, r4_r);

  always_comb begin
    st5_nxt      = st4_r;
    st5_nxt.clip = st4_r.clip | sq5.clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_r <= in_st;
      u1_r  <= u1_nxt;
      p1_r  <= RED_PW'(u1_nxt) * RED_PW'(RED_RM);
      st2_r <= st1_r;
      r2_r  <= RED_RW'(u1_r - RED_UW'(RED_UW'(q2) * RED_UW'(TWO_PI_FX)));
      st3_r <= st2_r;
      r3_r  <= r3_nxt;
      st4_r <= st3_r;
      r4_r  <= r4_nxt;
      st5_r <= st5_nxt;
      x2_r  <= sq5.v;
      r5_r  <= r4_r;
    end
  end

  assign hz_v[0]  = v5_r;
  assign hz_st[0] = st5_r;
  assign hz_x2[0] = x2_r;
  assign hz_r[0]  = r5_r;
  assign hz_t[0]  = ONE;

  for (genvar j = 0; j < NHORNER; j++) begin : g_horner
    logic                 a_v_r;
    st_t                  a_st_r;
    st_t                  a_st_nxt;
    logic signed [DW-1:0] a_x2_r;
    logic signed [DW-1:0] a_r_r;
    logic signed [DW-1:0] a_p_r;
    sres_t                pa;

    logic                 b_v_r;
    st_t                  b_st_r;
    logic signed [DW-1:0] b_x2_r;
    logic signed [DW-1:0] b_r_r;
    logic [DW-1:0]        b_n_r;
    logic                 b_neg_r;
    logic [2*DW-1:0]      b_prod_r;
    logic [DW-1:0]        n_nxt;

    logic                 c_v_r;
    st_t                  c_st_r;
    logic signed [DW-1:0] c_x2_r;
    logic signed [DW-1:0] c_r_r;
    logic signed [DW-1:0] c_t_r;
    logic [DW-1:0]        q0;
    logic [DW-1:0]        rem;
    logic [DW-1:0]        q;
    logic signed [DW-1:0] sq;
    logic signed [DW-1:0] t_nxt;

    assign pa = smul(hz_x2[j], hz_t[j]);
    assign n_nxt = a_p_r[DW-1] ? $unsigned(-a_p_r) : $unsigned(a_p_r);

    always_comb begin
      a_st_nxt      = hz_st[j];
      a_st_nxt.clip = hz_st[j].clip | pa.clip;
    end

    // quotient estimate is low by at most one
    always_comb begin
      q0 = DW'(b_prod_r >> DIV_SH[j]);
      rem = b_n_r - DW'(q0 * DW'(DIV_DEN[j]));
      q = (rem >= DW'(DIV_DEN[j])) ? q0 + 1'b1 : q0;
      sq = b_neg_r ? -$signed(q) : $signed(q);
      t_nxt = ONE - sq;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_v_r <= 1'b0;
        b_v_r <= 1'b0;
        c_v_r <= 1'b0;
      end else if (en) begin
        a_v_r <= hz_v[j];
        b_v_r <= a_v_r;
        c_v_r <= b_v_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_st_r      <= a_st_nxt;
        a_x2_r      <= hz_x2[j];
        a_r_r       <= hz_r[j];
        a_p_r       <= pa.v;
        b_st_r      <= a_st_r;
        b_x2_r      <= a_x2_r;
        b_r_r       <= a_r_r;
        b_n_r       <= n_nxt;
        b_neg_r     <= a_p_r[DW-1];
        b_prod_r    <= {{DW{1'b0}}, n_nxt} * {{DW{1'b0}}, DIV_MUL[j]};
        c_st_r      <= b_st_r;
        c_x2_r      <= b_x2_r;
        c_r_r       <= b_r_r;
        c_t_r       <= t_nxt;
      end
    end

    assign hz_v[j+1]  = c_v_r;
    assign hz_st[j+1] = c_st_r;
    assign hz_x2[j+1] = c_x2_r;
    assign hz_r[j+1]  = c_r_r;
    assign hz_t[j+1]  = c_t_r;
  end

  assign sn = smul(hz_r[NHORNER], hz_t[NHORNER]);

  always_comb begin
    sto_nxt      = hz_st[NHORNER];
    sto_nxt.clip = hz_st[NHORNER].clip | sn.clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= hz_v[NHORNER];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sto_r <= sto_nxt;
      sin_r <= sn.v;
    end
  end

  assign out_valid = vo_r;
  assign out_st    = sto_r;
  assign out_sin   = sin_r;

endmodule

// ===== rtl/prk_accel.sv =====
`timescale 1ns / 1ps
module prk_accel (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  prk_pkg::st_t                 in_st,
  input  logic [30:0]                  gravity,
  output logic                         out_valid,
  output prk_pkg::st_t                 out_st,
  output logic signed [prk_pkg::DW-1:0] out_wk
);
  import prk_pkg::*;

  logic                 s_v;
  st_t                  s_st;
  logic signed [DW-1:0] s_sin;

  sres_t                g;
  st_t                  g_st_nxt;
  logic                 g_v_r;
  st_t                  g_st_r;
  logic signed [DW-1:0] g_r;

  sres_t                wk;
  st_t                  w_st_nxt;
  logic                 w_v_r;
  st_t                  w_st_r;
  logic signed [DW-1:0] wk_r;

  prk_sin u_sin (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_st     (in_st),
    .out_valid (s_v),
    .out_st    (s_st),
    .out_sin   (s_sin)
  );

  assign g  = smul($signed({1'b0, gravity}), s_sin);
  assign wk = sadd(g_st_r.drive, g_r);

  always_comb begin
    g_st_nxt      = s_st;
    g_st_nxt.clip = s_st.clip | g.clip;
    w_st_nxt      = g_st_r;
    w_st_nxt.clip = g_st_r.clip | wk.clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
      w_v_r <= 1'b0;
    end else if (en) begin
      g_v_r <= s_v;
      w_v_r <= g_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_st_r <= g_st_nxt;
      g_r    <= g.v;
      w_st_r <= w_st_nxt;
      wk_r   <= wk.v;
    end
  end

  assign out_valid = w_v_r;
  assign out_st    = w_st_r;
  assign out_wk    = wk_r;

endmodule

// ===== rtl/pendulum_rk4_step.sv =====
`timescale 1ns / 1ps
// One fourth-order Runge-Kutta step of a driven pendulum, signed Q8.24.
// Input channel: in_valid / in_stall carry angle, angular rate and torque.
// Output channel: out_valid / out_stall carry the new angle and rate and a
// flag that is set when any add, negate or multiply of the step saturated.
// Items are independent: one request enters per cycle while in_stall is low,
// so a new request can be taken before earlier ones finish. Each result
// passes through four angle-to-acceleration evaluations in series, each a
// 23 stage sine and scale pipeline, plus the update stages.
// When out_stall holds a waiting result, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr
// (0 step size, 1 drive gain, 2 gravity coefficient, 3 ignored). Write only
// while no item is in flight.
// Reset (rst_n low, synchronous) empties the pipeline and loads the default
// step size, drive gain and gravity coefficient.
module pendulum_rk4_step (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [prk_pkg::DW-1:0] in_angle_in,
  input  logic signed [prk_pkg::DW-1:0] in_rate_in,
  input  logic signed [prk_pkg::DW-1:0] in_torque,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [prk_pkg::DW-1:0] out_angle_out,
  output logic signed [prk_pkg::DW-1:0] out_rate_out,
  output logic                          out_saturated,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_addr,
  input  logic [30:0]                   cfg_wdata
);
  import prk_pkg::*;

  logic [24:0] step_r;
  logic [24:0] h6_r;
  logic [30:0] gain_r;
  logic [30:0] grav_r;

  logic signed [DW-1:0] h_full;
  logic signed [DW-1:0] h_half;
  logic signed [DW-1:0] h_sixth;

  logic en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RST;
      h6_r   <= H6_RST;
      gain_r <= DRIVE_RST;
      grav_r <= GRAVITY_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_STEP: begin
          step_r <= cfg_wdata[24:0];
          h6_r   <= 25'((64'(cfg_wdata[24:0]) * H6_MUL) >> H6_SH);
        end
        REG_DRIVE:   gain_r <= cfg_wdata;
        REG_GRAVITY: grav_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign h_full  = $signed(DW'(step_r));
  assign h_half  = $signed(DW'(step_r[24:1]));
  assign h_sixth = $signed(DW'(h6_r));

  // the pipeline moves unless a finished result is held by the receiver
  logic out_v_r;
  assign en       = !out_v_r || !out_stall;
  assign in_stall = !en;

  // entry stage: drive term and first slope of the angle
  sres_t drv;
  sres_t ok1;
  st_t   e_nxt;
  logic  e_v_r;
  st_t   e_st_r;

  assign drv = smul($signed({1'b0, gain_r}), in_torque);
  assign ok1 = sneg(in_rate_in);

  always_comb begin
    e_nxt.th0   = in_angle_in;
    e_nxt.w0    = in_rate_in;
    e_nxt.drive = drv.v;
    e_nxt.thc   = in_angle_in;
    e_nxt.okc   = ok1.v;
    e_nxt.so    = '0;
    e_nxt.sw    = '0;
    e_nxt.clip  = drv.clip | ok1.clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_st_r <= e_nxt;
    end
  end

  logic                 ac_v_in   [NEVAL];
  st_t                  ac_st_in  [NEVAL];
  logic                 ac_v_out  [NEVAL];
  st_t                  ac_st_out [NEVAL];
  logic signed [DW-1:0] ac_wk     [NEVAL];

  assign ac_v_in[0]  = e_v_r;
  assign ac_st_in[0] = e_st_r;

  for (genvar k = 0; k < NEVAL; k++) begin : g_eval
    prk_accel u_accel (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (ac_v_in[k]),
      .in_st     (ac_st_in[k]),
      .gravity   (grav_r),
      .out_valid (ac_v_out[k]),
      .out_st    (ac_st_out[k]),
      .out_wk    (ac_wk[k])
    );

    if (k < NEVAL - 1) begin : g_update
      logic signed [DW-1:0] hc;
      st_t                  a_nxt;
      logic                 a_v_r;
      st_t                  a_st_r;
      logic signed [DW-1:0] a_m1_r;
      logic signed [DW-1:0] a_mt_r;
      st_t                  b_nxt;
      logic                 b_v_r;
      st_t                  b_st_r;

      assign hc = (k == NEVAL - 2) ? h_full : h_half;

      sres_t m1;
      sres_t mt;
      sres_t d_ok;
      sres_t d_wk;
      sres_t a_so;
      sres_t a_sw;
      sres_t nw;
      sres_t nth;
      sres_t nok;

      assign m1   = smul(ac_wk[k], hc);
      assign mt   = smul(ac_st_out[k].okc, hc);
      assign d_ok = sadd(ac_st_out[k].okc, ac_st_out[k].okc);
      assign d_wk = sadd(ac_wk[k], ac_wk[k]);
      assign a_so = sadd(ac_st_out[k].so, d_ok.v);
      assign a_sw = sadd(ac_st_out[k].sw, d_wk.v);

      // running slope sums: first slope once, middle slopes twice
      always_comb begin
        a_nxt = ac_st_out[k];
        if (k == 0) begin
          a_nxt.so   = ac_st_out[k].okc;
          a_nxt.sw   = ac_wk[k];
          a_nxt.clip = ac_st_out[k].clip | m1.clip | mt.clip;
        end else begin
          a_nxt.so   = a_so.v;
          a_nxt.sw   = a_sw.v;
          a_nxt.clip = ac_st_out[k].clip | m1.clip | mt.clip | d_ok.clip |
                       d_wk.clip | a_so.clip | a_sw.clip;
        end
      end

      assign nw  = sadd(a_st_r.w0, a_m1_r);
      assign nth = sadd(a_st_r.th0, a_mt_r);
      assign nok = sneg(nw.v);

      always_comb begin
        b_nxt      = a_st_r;
        b_nxt.thc  = nth.v;
        b_nxt.okc  = nok.v;
        b_nxt.clip = a_st_r.clip | nw.clip | nth.clip | nok.clip;
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          a_v_r <= 1'b0;
          b_v_r <= 1'b0;
        end else if (en) begin
          a_v_r <= ac_v_out[k];
          b_v_r <= a_v_r;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          a_st_r <= a_nxt;
          a_m1_r <= m1.v;
          a_mt_r <= mt.v;
          b_st_r <= b_nxt;
        end
      end

      assign ac_v_in[k+1]  = b_v_r;
      assign ac_st_in[k+1] = b_st_r;
    end
  end

  // final sums, scale by h/6, add to the start state
  sres_t f_so;
  sres_t f_sw;
  st_t   fa_st_nxt;
  logic  fa_v_r;
  st_t   fa_st_r;
  logic signed [DW-1:0] fa_so_r;
  logic signed [DW-1:0] fa_sw_r;

  assign f_so = sadd(ac_st_out[NEVAL-1].so, ac_st_out[NEVAL-1].okc);
  assign f_sw = sadd(ac_st_out[NEVAL-1].sw, ac_wk[NEVAL-1]);

  always_comb begin
    fa_st_nxt      = ac_st_out[NEVAL-1];
    fa_st_nxt.clip = ac_st_out[NEVAL-1].clip | f_so.clip | f_sw.clip;
  end

  sres_t f_mo;
  sres_t f_mw;
  st_t   fb_st_nxt;
  logic  fb_v_r;
  st_t   fb_st_r;
  logic signed [DW-1:0] fb_mo_r;
  logic signed [DW-1:0] fb_mw_r;

  assign f_mo = smul(fa_so_r, h_sixth);
  assign f_mw = smul(fa_sw_r, h_sixth);

  always_comb begin
    fb_st_nxt      = fa_st_r;
    fb_st_nxt.clip = fa_st_r.clip | f_mo.clip | f_mw.clip;
  end

  sres_t f_th;
  sres_t f_w;
  logic signed [DW-1:0] out_angle_r;
  logic signed [DW-1:0] out_rate_r;
  logic                 out_sat_r;

  assign f_th = sadd(fb_st_r.th0, fb_mo_r);
  assign f_w  = sadd(fb_st_r.w0, fb_mw_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_v_r  <= 1'b0;
      fb_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      fa_v_r  <= ac_v_out[NEVAL-1];
      fb_v_r  <= fa_v_r;
      out_v_r <= fb_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fa_st_r      <= fa_st_nxt;
      fa_so_r      <= f_so.v;
      fa_sw_r      <= f_sw.v;
      fb_st_r      <= fb_st_nxt;
      fb_mo_r      <= f_mo.v;
      fb_mw_r      <= f_mw.v;
      out_angle_r  <= f_th.v;
      out_rate_r   <= f_w.v;
      out_sat_r    <= fb_st_r.clip | f_th.clip | f_w.clip;
    end
  end

  assign out_valid     = out_v_r;
  assign out_angle_out = out_angle_r;
  assign out_rate_out  = out_rate_r;
  assign out_saturated = out_sat_r;

endmodule

// ===== dv/tb_pendulum_rk4_step.sv =====
`timescale 1ns / 1ps
module tb_pendulum_rk4_step;
  import prk_pkg::*;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
    logic               sat;
  } swing_t;

  // fixed-point pendulum arithmetic, saturation noted in a sticky flag
  class pendulum_board;
    longint unsigned step_h;
    longint unsigned gain;
    longint unsigned grav;
    bit clipped;
    swing_t pending[$];
    int errors;

    function new();
      step_h = 167772;
      gain = 166111;
      grav = 253241674;
      errors = 0;
    endfunction

    function longint lim(longint v);
      if (v > 64'sd2147483647) begin
        clipped = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        clipped = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint neg_sat(longint a);
      return lim(-a);
    endfunction

    function longint mul_sat(longint a, longint b);
      logic [127:0] ua;
      logic [127:0] ub;
      logic [127:0] q;
      logic [127:0] top;
      bit n;
      n = (a < 0) != (b < 0);
      ua = a < 0 ? 128'(-a) : 128'(a);
      ub = b < 0 ? 128'(-b) : 128'(b);
      q = (ua * ub) >> 24;
      top = n ? 128'h8000_0000 : 128'h7fff_ffff;
      if (q > top) begin
        clipped = 1;
        q = top;
      end
      return n ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function longint sine(longint a);
      longint pi_v;
      longint half_v;
      longint one_v;
      longint r;
      longint x2;
      longint t;
      int dens[5];
      dens = '{110, 72, 42, 20, 6};
      pi_v = longint'(PI_FX);
      half_v = longint'(HALF_FX);
      one_v = 64'sd1 << 24;
      r = a % (2 * pi_v);
      if (r < 0) r += 2 * pi_v;
      if (r >= pi_v) r -= 2 * pi_v;
      if (r > half_v) r = pi_v - r;
      else if (r < -half_v) r = -pi_v - r;
      x2 = mul_sat(r, r);
      t = one_v;
      foreach (dens[i]) t = one_v - mul_sat(x2, t) / dens[i];
      return mul_sat(r, t);
    endfunction

    function longint accel(longint drv, longint th);
      return lim(drv + mul_sat(longint'(grav), sine(th)));
    endfunction

    function longint weigh(longint k1, longint k2, longint k3, longint k4);
      longint s;
      s = lim(k1 + lim(k2 + k2));
      s = lim(s + lim(k3 + k3));
      return lim(s + k4);
    endfunction

    function void note_request(logic signed [31:0] th_i, logic signed [31:0] w_i,
                               logic signed [31:0] tq_i);
      longint th, w, h, h2, h6, drv;
      longint o1, o2, o3, o4, a1, a2, a3, a4, t1, t2, t3, w1, w2, w3;
      swing_t e;
      th = th_i;
      w = w_i;
      h = longint'(step_h);
      h2 = h >>> 1;
      h6 = h / 6;
      clipped = 0;
      drv = mul_sat(longint'(gain), longint'(tq_i));
      o1 = neg_sat(w);
      a1 = accel(drv, th);
      t1 = lim(th + mul_sat(o1, h2));
      w1 = lim(w + mul_sat(a1, h2));
      o2 = neg_sat(w1);
      a2 = accel(drv, t1);
      t2 = lim(th + mul_sat(o2, h2));
      w2 = lim(w + mul_sat(a2, h2));
      o3 = neg_sat(w2);
      a3 = accel(drv, t2);
      t3 = lim(th + mul_sat(o3, h));
      w3 = lim(w + mul_sat(a3, h));
      o4 = neg_sat(w3);
      a4 = accel(drv, t3);
      e.angle = 32'(lim(th + mul_sat(weigh(o1, o2, o3, o4), h6)));
      e.rate = 32'(lim(w + mul_sat(weigh(a1, a2, a3, a4), h6)));
      e.sat = clipped;
      pending.push_back(e);
    endfunction

    function void check_result(logic signed [31:0] ang, logic signed [31:0] rt,
                               logic sat);
      swing_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result angle %0d rate %0d", $time, ang, rt);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (ang !== e.angle) begin
        $display("%0t angle exp %0d got %0d", $time, e.angle, ang);
        errors++;
      end
      if (rt !== e.rate) begin
        $display("%0t rate exp %0d got %0d", $time, e.rate, rt);
        errors++;
      end
      if (sat !== e.sat) begin
        $display("%0t saturated exp %0b got %0b", $time, e.sat, sat);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic signed [31:0] in_angle_in = 0;
  logic signed [31:0] in_rate_in = 0;
  logic signed [31:0] in_torque = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] out_angle_out;
  logic signed [31:0] out_rate_out;
  logic out_saturated;
  logic cfg_we = 0;
  logic [1:0] cfg_addr = REG_STEP;
  logic [30:0] cfg_wdata = 0;

  pendulum_board board = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;

  always #5 clk = ~clk;

  pendulum_rk4_step dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_angle_out, out_rate_out, out_saturated);
  end

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  // the request stays up after acceptance; the next call replaces or lowers it, drain lowers it
  task automatic send_swing(logic signed [31:0] th, logic signed [31:0] w,
                            logic signed [31:0] tq);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_angle_in <= th;
    in_rate_in <= w;
    in_torque <= tq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(th, w, tq);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == REG_STEP) board.step_h = val[24:0];
    else if (idx == REG_DRIVE) board.gain = val;
    else if (idx == REG_GRAVITY) board.grav = val;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(200000000)) - 100000000);
      default: return 32'($signed($urandom_range(60000000)) - 30000000);
    endcase
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        send_swing($urandom, $urandom, $urandom);
      else
        send_swing(pick_angle(), 32'($signed($urandom_range(200000000)) - 100000000),
                   32'($signed($urandom_range(400000000)) - 200000000));
    end
  endtask

  initial begin
    logic signed [31:0] edges[6];
    edges = '{32'sh7fffffff, 32'sh80000000, 0, 32'sd1, -32'sd1, 32'sd52707179};
    repeat (7) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    foreach (edges[i]) send_swing(edges[i], edges[5 - i], edges[(i + 2) % 6]);
    send_swing(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_swing(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    drain();
    write_reg(REG_STEP, 0);
    send_swing(32'sd12345678, -32'sd999, 32'sd5);
    drain();
    write_reg(REG_STEP, 31'h1ffffff);
    write_reg(REG_DRIVE, 31'h7fffffff);
    write_reg(REG_GRAVITY, 31'h7fffffff);
    write_reg(2'd3, 31'h1234);
    send_swing(32'sd26353589, 32'sd16777216, -32'sd16777216);
    send_swing(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    drain();
    write_reg(REG_STEP, 1);
    write_reg(REG_DRIVE, 0);
    write_reg(REG_GRAVITY, 0);
    send_swing(32'sd100, 32'sd100, 32'sd100);
    drain();
    write_reg(REG_STEP, 167772);
    write_reg(REG_DRIVE, 166111);
    write_reg(REG_GRAVITY, 253241674);
    random_phase(500);
    send_idle_pct = 69;
    random_phase(450);
    drain();
    write_reg(REG_STEP, $urandom_range(1, 1 << 24));
    write_reg(REG_DRIVE, $urandom_range(0, 2000000));
    write_reg(REG_GRAVITY, $urandom_range(0, 400000000));
    send_idle_pct = 0;
    recv_stall_pct = 69;
    random_phase(450);
    send_idle_pct = 16;
    recv_stall_pct = 16;
    random_phase(450);
    drain();
    recv_stall_pct = 0;
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== pendulum_rk4_step.f =====
rtl/prk_pkg.sv
rtl/prk_sin.sv
rtl/prk_accel.sv
rtl/pendulum_rk4_step.sv
dv/tb_pendulum_rk4_step.sv
